// ===== design/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/msd_pkg.sv =====
// Types and constants for the MIDI stream decoder.
package msd_pkg;

	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 56;
	localparam int unsigned MAX_RES    = 3;

	typedef enum logic [4:0] {
		K_NOTEOFF     = 5'd0,
		K_NOTEON      = 5'd1,
		K_POLYPRESS   = 5'd2,
		K_CC          = 5'd3,
		K_PROG        = 5'd4,
		K_CHANPRESS   = 5'd5,
		K_BEND        = 5'd6,
		K_LOCAL       = 5'd7,
		K_ALLNOTESOFF = 5'd8,
		K_OMNI        = 5'd9,
		K_MONO        = 5'd10,
		K_POLY        = 5'd11,
		K_SONGPOS     = 5'd12,
		K_SONGSEL     = 5'd13,
		K_SYSTEM      = 5'd14,
		K_SYSEXBYTE   = 5'd15,
		K_SYSEXEND    = 5'd16
	} kind_t;

	typedef struct packed {
		logic               last;
		logic               flag_on;
		logic [13:0]        song_pos;
		logic signed [13:0] bend;
		logic [6:0]         amount;
		logic [6:0]         number;
		logic [3:0]         channel;
		kind_t              event_kind;
	} result_t;

	// status high nibbles
	localparam logic [3:0] MSG_NOTEOFF = 4'h8;
	localparam logic [3:0] MSG_NOTEON  = 4'h9;
	localparam logic [3:0] MSG_POLYPR  = 4'hA;
	localparam logic [3:0] MSG_CC      = 4'hB;
	localparam logic [3:0] MSG_PROG    = 4'hC;
	localparam logic [3:0] MSG_CHPRESS = 4'hD;
	localparam logic [3:0] MSG_BEND    = 4'hE;
	localparam logic [3:0] MSG_SYS     = 4'hF;

	// system status bytes
	localparam logic [7:0] ST_NONE    = 8'h00;
	localparam logic [7:0] ST_SYSEX   = 8'hF0;
	localparam logic [7:0] ST_SONGPOS = 8'hF2;
	localparam logic [7:0] ST_SONGSEL = 8'hF3;
	localparam logic [7:0] ST_TUNE    = 8'hF6;
	localparam logic [7:0] ST_EOX     = 8'hF7;
	localparam logic [4:0] RT_PREFIX  = 5'b11111;

	// mode controllers
	localparam logic [6:0] CC_LOCAL    = 7'd122;
	localparam logic [6:0] CC_ALLOFF   = 7'd123;
	localparam logic [6:0] CC_OMNI_OFF = 7'd124;
	localparam logic [6:0] CC_OMNI_ON  = 7'd125;
	localparam logic [6:0] CC_MONO     = 7'd126;
	localparam logic [6:0] CC_POLY     = 7'd127;

	// system codes in the number field
	localparam logic [6:0] SYS_TUNE   = 7'd0;
	localparam logic [6:0] SYS_CLOCK  = 7'd1;
	localparam logic [6:0] SYS_START  = 7'd2;
	localparam logic [6:0] SYS_CONT   = 7'd3;
	localparam logic [6:0] SYS_STOP   = 7'd4;
	localparam logic [6:0] SYS_SENSE  = 7'd5;
	localparam logic [6:0] SYS_RESET  = 7'd6;

	// low three bits of realtime bytes 0xF8..0xFF
	localparam logic [2:0] RT_CLOCK = 3'd0;
	localparam logic [2:0] RT_UNDEF9 = 3'd1;
	localparam logic [2:0] RT_START = 3'd2;
	localparam logic [2:0] RT_CONT  = 3'd3;
	localparam logic [2:0] RT_STOP  = 3'd4;
	localparam logic [2:0] RT_UNDEFD = 3'd5;
	localparam logic [2:0] RT_SENSE = 3'd6;
	localparam logic [2:0] RT_RESET = 3'd7;

endpackage

// ===== design/midi_stream_decoder.sv =====
// MIDI stream decoder top level: input stage, decoder, result group stage.
//
// Slave channel s_*: one MIDI byte per beat in s_tdata[7:0].
// Master channel m_*: one decoded event per beat; m_tlast marks the last
// event caused by a byte. A byte may cause zero to three events.
// A byte is registered in the input stage on accept, then decoded, and its
// events are loaded into the group register, from which they are sent.
// Bytes with at most one event stream at one byte per cycle while the
// receiver does not stall; a byte with more than one event holds the input
// stage until the group register has sent them all, one event per beat.
// Bytes that give no event pass through without using an output beat.
// When the receiver stalls, the group register holds its event and the input
// register still takes one more byte; after that s_tready drops.
// Reset clears running status, pending data byte and SysEx flag, and empties
// both stages.
`include "assert_macros.svh"

module midi_stream_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [msd_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] midi_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [4:0] event_kind, [8:5] channel, [15:9] number, [22:16] amount,
	// [36:23] bend, [50:37] song_pos, [51] flag_on, [55:52] zero
	output logic [msd_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);

	logic [7:0] byte_s1;
	logic       valid_s1;
	msd_pkg::result_t [msd_pkg::MAX_RES-1:0] grp_s2;
	logic [1:0] cnt_s2;
	logic [1:0] idx_q;

	msd_pkg::result_t [msd_pkg::MAX_RES-1:0] dec_res;
	logic [1:0] dec_n;
	logic       grp_free;
	logic       step;
	logic       in_beat;
	logic       out_beat;
	msd_pkg::result_t cur;

	assign out_beat = m_tvalid && m_tready;
	assign grp_free = (cnt_s2 == 2'd0) || (out_beat && (idx_q == cnt_s2 - 2'd1));
	assign step     = valid_s1 && grp_free;
	assign s_tready = !valid_s1 || grp_free;
	assign in_beat  = s_tvalid && s_tready;

	msd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.midi_byte (byte_s1),
		.res       (dec_res),
		.n_res     (dec_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat)
			byte_s1 <= s_tdata[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
			idx_q  <= 2'd0;
		end else if (grp_free) begin
			cnt_s2 <= step ? dec_n : 2'd0;
			idx_q  <= 2'd0;
		end else if (out_beat) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			grp_s2 <= dec_res;
	end

	assign cur      = grp_s2[idx_q];
	assign m_tvalid = cnt_s2 != 2'd0;
	assign m_tlast  = cur.last;
	assign m_tdata  = {4'd0, cur.flag_on, cur.song_pos, cur.bend, cur.amount,
		cur.number, cur.channel, cur.event_kind};

	`MSD_ASSERT_NOW(a_idx_in_group, cnt_s2 != 2'd0, idx_q < cnt_s2,
		"event index past group size")
	`MSD_ASSERT_NEXT(a_group_continues, out_beat && !m_tlast, m_tvalid,
		"group ended before its last event")
	`MSD_ASSERT_NOW(a_stall_means_full, !s_tready, valid_s1,
		"input stalled with empty input stage")

endmodule

// ===== design/msd_decode.sv =====
// Parser state and per-byte decode into up to three results.
`include "assert_macros.svh"

module msd_decode (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    step,
	input  logic [7:0]                              midi_byte,
	output msd_pkg::result_t [msd_pkg::MAX_RES-1:0] res,
	output logic [1:0]                              n_res
);

	logic [7:0] status_q, status_d;
	logic [6:0] first_q, first_d;
	logic       have_first_q, have_first_d;
	logic       sysex_q, sysex_d;

	logic [3:0] msg;
	logic [3:0] ch;
	logic [6:0] b7;
	logic [6:0] d0;
	logic [6:0] d1;
	logic       need_one;
	logic       need_two;
	logic       two;
	msd_pkg::result_t [msd_pkg::MAX_RES-1:0] r;
	logic [1:0] n;

	function automatic msd_pkg::result_t mk(msd_pkg::kind_t kind, logic [3:0] c,
			logic [6:0] num, logic [6:0] amt, logic signed [13:0] bnd,
			logic [13:0] pos, logic flag);
		msd_pkg::result_t x;
		x.last       = 1'b0;
		x.flag_on    = flag;
		x.song_pos   = pos;
		x.bend       = bnd;
		x.amount     = amt;
		x.number     = num;
		x.channel    = c;
		x.event_kind = kind;
		return x;
	endfunction

	assign msg      = status_q[7:4];
	assign ch       = status_q[3:0];
	assign b7       = midi_byte[6:0];
	assign need_one = (msg == msd_pkg::MSG_PROG) || (msg == msd_pkg::MSG_CHPRESS) ||
		(status_q == msd_pkg::ST_SONGSEL);
	assign need_two = (msg != msd_pkg::MSG_SYS) || (status_q == msd_pkg::ST_SONGPOS);
	assign two      = need_two && !need_one;
	assign d0       = two ? first_q : b7;
	assign d1       = b7;

	always_comb begin
		status_d     = status_q;
		first_d      = first_q;
		have_first_d = have_first_q;
		sysex_d      = sysex_q;
		r            = '0;
		n            = 2'd0;
		priority if (!midi_byte[7]) begin
			if (sysex_q) begin
				r[0] = mk(msd_pkg::K_SYSEXBYTE, '0, b7, '0, '0, '0, 1'b0);
				n    = 2'd1;
			end else if (!status_q[7] || !(need_one || need_two)) begin
				// no usable running status: byte dropped
				n = 2'd0;
			end else if (two && !have_first_q) begin
				first_d      = b7;
				have_first_d = 1'b1;
			end else begin
				have_first_d = 1'b0;
				n            = 2'd1;
				unique case (msg)
					msd_pkg::MSG_NOTEOFF:
						r[0] = mk(msd_pkg::K_NOTEOFF, ch, d0, d1, '0, '0, 1'b0);
					msd_pkg::MSG_NOTEON:
						r[0] = mk((d1 != 7'd0) ? msd_pkg::K_NOTEON : msd_pkg::K_NOTEOFF,
							ch, d0, d1, '0, '0, 1'b0);
					msd_pkg::MSG_POLYPR:
						r[0] = mk(msd_pkg::K_POLYPRESS, ch, d0, d1, '0, '0, 1'b0);
					msd_pkg::MSG_PROG:
						r[0] = mk(msd_pkg::K_PROG, ch, d0, '0, '0, '0, 1'b0);
					msd_pkg::MSG_CHPRESS:
						r[0] = mk(msd_pkg::K_CHANPRESS, ch, '0, d0, '0, '0, 1'b0);
					msd_pkg::MSG_BEND:
						// minus 0x2000 on 14 bits flips the top bit
						r[0] = mk(msd_pkg::K_BEND, ch, '0, '0,
							$signed({~d1[6], d1[5:0], d0}), '0, 1'b0);
					msd_pkg::MSG_CC: begin
						priority if (d0 == msd_pkg::CC_LOCAL) begin
							r[0] = mk(msd_pkg::K_LOCAL, ch, '0, '0, '0, '0, d1 != 7'd0);
						end else if (d0 >= msd_pkg::CC_ALLOFF) begin
							r[0] = mk(msd_pkg::K_ALLNOTESOFF, ch, '0, '0, '0, '0, 1'b0);
							priority if (d0 == msd_pkg::CC_OMNI_OFF ||
									d0 == msd_pkg::CC_OMNI_ON) begin
								r[1] = mk(msd_pkg::K_OMNI, ch, '0, '0, '0, '0,
									d0 == msd_pkg::CC_OMNI_ON);
								n    = 2'd2;
							end else if (d0 == msd_pkg::CC_MONO) begin
								r[1] = mk(msd_pkg::K_OMNI, ch, '0, '0, '0, '0,
									d1[3:0] == 4'd0);
								r[2] = mk(msd_pkg::K_MONO, ch, '0, {3'd0, d1[3:0]},
									'0, '0, 1'b0);
								n    = 2'd3;
							end else if (d0 == msd_pkg::CC_POLY) begin
								r[1] = mk(msd_pkg::K_POLY, ch, '0, '0, '0, '0, 1'b0);
								n    = 2'd2;
							end else begin
								n = 2'd1;
							end
						end else begin
							r[0] = mk(msd_pkg::K_CC, ch, d0, d1, '0, '0, 1'b0);
						end
					end
					msd_pkg::MSG_SYS: begin
						if (status_q == msd_pkg::ST_SONGPOS)
							r[0] = mk(msd_pkg::K_SONGPOS, '0, '0, '0, '0, {d1, d0}, 1'b0);
						else
							r[0] = mk(msd_pkg::K_SONGSEL, '0, d0, '0, '0, '0, 1'b0);
						status_d = msd_pkg::ST_NONE;
					end
					default: n = 2'd0;
				endcase
			end
		end else if (midi_byte[7:3] == msd_pkg::RT_PREFIX) begin
			// realtime: no state change
			n = 2'd1;
			unique case (midi_byte[2:0])
				msd_pkg::RT_CLOCK:
					r[0] = mk(msd_pkg::K_SYSTEM, '0, msd_pkg::SYS_CLOCK, '0, '0, '0, 1'b0);
				msd_pkg::RT_START:
					r[0] = mk(msd_pkg::K_SYSTEM, '0, msd_pkg::SYS_START, '0, '0, '0, 1'b0);
				msd_pkg::RT_CONT:
					r[0] = mk(msd_pkg::K_SYSTEM, '0, msd_pkg::SYS_CONT, '0, '0, '0, 1'b0);
				msd_pkg::RT_STOP:
					r[0] = mk(msd_pkg::K_SYSTEM, '0, msd_pkg::SYS_STOP, '0, '0, '0, 1'b0);
				msd_pkg::RT_SENSE:
					r[0] = mk(msd_pkg::K_SYSTEM, '0, msd_pkg::SYS_SENSE, '0, '0, '0, 1'b0);
				msd_pkg::RT_RESET:
					r[0] = mk(msd_pkg::K_SYSTEM, '0, msd_pkg::SYS_RESET, '0, '0, '0, 1'b0);
				msd_pkg::RT_UNDEF9, msd_pkg::RT_UNDEFD:
					n = 2'd0;
				default: n = 2'd0;
			endcase
		end else begin
			have_first_d = 1'b0;
			if (msg != msd_pkg::MSG_SYS || midi_byte[7:4] != msd_pkg::MSG_SYS) begin
				n = 2'd0;
			end
			if (midi_byte[7:4] != msd_pkg::MSG_SYS) begin
				status_d = midi_byte;
				sysex_d  = 1'b0;
			end else begin
				status_d = msd_pkg::ST_NONE;
				priority if (midi_byte == msd_pkg::ST_SYSEX) begin
					sysex_d = 1'b1;
				end else if (midi_byte == msd_pkg::ST_EOX) begin
					if (sysex_q) begin
						r[0] = mk(msd_pkg::K_SYSEXEND, '0, '0, '0, '0, '0, 1'b0);
						n    = 2'd1;
					end
					sysex_d = 1'b0;
				end else begin
					sysex_d = 1'b0;
					if (midi_byte == msd_pkg::ST_SONGPOS || midi_byte == msd_pkg::ST_SONGSEL)
						status_d = midi_byte;
					else if (midi_byte == msd_pkg::ST_TUNE) begin
						r[0] = mk(msd_pkg::K_SYSTEM, '0, msd_pkg::SYS_TUNE, '0, '0, '0, 1'b0);
						n    = 2'd1;
					end
				end
			end
		end
	end

	// flag the final result of this byte
	always_comb begin
		res = r;
		if (n != 2'd0)
			res[n - 2'd1].last = 1'b1;
	end

	assign n_res = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= msd_pkg::ST_NONE;
			first_q      <= '0;
			have_first_q <= 1'b0;
			sysex_q      <= 1'b0;
		end else if (step) begin
			status_q     <= status_d;
			first_q      <= first_d;
			have_first_q <= have_first_d;
			sysex_q      <= sysex_d;
		end
	end

	`MSD_ASSERT_NEXT(a_status_clears_count,
		step && midi_byte[7] && (midi_byte[7:3] != msd_pkg::RT_PREFIX),
		!have_first_q, "status byte left a pending data byte")
	`MSD_ASSERT_NOW(a_sysex_passes_data, step && sysex_q && !midi_byte[7],
		n == 2'd1, "sysex data byte not passed on")

endmodule
